[rtl/bcv_pkg.sv]
// Shared types and constants for the bounding cylinder block.
// Used by bcv_sqrt and by the bounding_cylinder_from_vertices top level.
package bcv_pkg;

  // Width of every result field.
  localparam int unsigned OUT_W = 16;
  // Number of result fields packed into out_tdata.
  localparam int unsigned OUT_FIELDS = 6;

  // Status that the root unit reports to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } bcv_root_stat_t;

endpackage

[rtl/bcv_sqrt.sv]
// Iterative floor square root: one result bit per cycle, restoring method.
// Depends on bcv_pkg for the status struct.
module bcv_sqrt import bcv_pkg::*; #(
  parameter int unsigned ROOT_W = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic [ROOT_W-1:0]     root,
  output bcv_root_stat_t        stat
);

  localparam int unsigned CNT_W = $clog2(ROOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);
  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned SH_W  = ROOT_W + 4;

  logic [2*ROOT_W-1:0] rad_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;

  logic [SH_W-1:0]     rem_sh;
  logic [SH_W-1:0]     trial;
  logic [SH_W-1:0]     diff;
  logic                ge;
  logic [REM_W-1:0]    rem_nxt;
  logic [ROOT_W-1:0]   root_nxt;

  // Bring down the next two radicand bits and try the next root bit
  assign rem_sh   = {rem_r, rad_r[2*ROOT_W-1 -: 2]};
  assign trial    = {2'b00, root_r, 2'b01};
  assign diff     = rem_sh - trial;
  assign ge       = (rem_sh >= trial);
  assign rem_nxt  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
  assign root_nxt = {root_r[ROOT_W-2:0], ge};

  // Step the digit recurrence while busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNT_LAST;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rad_r  <= {rad_r[2*ROOT_W-3:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[rtl/bounding_cylinder_from_vertices.sv]
// Bounding cylinder of a vertex stream: min/max y, largest x*x+z*z, and roots.
// A new vertex is taken only in S_IDLE, after S_SQX, S_SQZ and S_ACC of the previous one
// (the shared squarer is used twice per vertex). After the last vertex the result waits on
// three passes through the one-bit-per-cycle root unit: radius, bottom edge, top edge.
// Reset (rst_n low, synchronous) clears the running min/max y and largest x*x+z*z and drops any result.
// Depends on bcv_pkg and bcv_sqrt.
module bounding_cylinder_from_vertices import bcv_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // vert_x, vert_y, vert_z (COORD_WIDTH bits each), zero padding to bytes
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]      in_tdata,
  input  logic                                    in_tlast,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // lowest_y, highest_y, radius_out, bottom_edge_dist, top_edge_dist,
  // depth_any_rotation (16 bits each)
  output logic [OUT_FIELDS*OUT_W-1:0]             out_tdata
);

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned SUM_W  = 2 * CW;
  localparam int unsigned EDGE_W = CW + 1;
  localparam int unsigned SEXT_W = (CW > OUT_W) ? CW : OUT_W;
  localparam int unsigned UEXT_W = (EDGE_W > OUT_W) ? EDGE_W : OUT_W;
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_SQX, S_SQZ, S_ACC, S_YSQ, S_GO, S_WAIT, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SEL_RADIUS, SEL_BOTTOM, SEL_TOP
  } root_sel_t;

  state_t                 state_r;
  root_sel_t              sel_r;

  logic signed [CW-1:0]   x_r, y_r, z_r;
  logic                   last_r;
  logic signed [CW-1:0]   min_y_r, max_y_r;
  logic [SUM_W-1:0]       max_rsq_r;
  logic [SUM_W-1:0]       p_r;
  logic [SUM_W-1:0]       acc_r;
  logic [CW-1:0]          radius_r;
  logic [EDGE_W-1:0]      bottom_r, top_r;
  logic                   out_valid_r;
  logic [OUT_FIELDS*OUT_W-1:0] out_data_r;

  logic [CW-1:0]          mul_a;
  logic [SUM_W-1:0]       mul_p;
  logic [SUM_W-1:0]       rsq;
  logic [SUM_W-1:0]       radicand;
  logic                   root_start;
  logic [CW-1:0]          root;
  bcv_root_stat_t         root_stat;

  logic [EDGE_W-1:0]      depth;
  logic signed [SEXT_W-1:0] min_ext, max_ext;
  logic [UEXT_W-1:0]      rad_ext, bot_ext, top_ext, dep_ext;

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    mag = v[CW-1] ? (~v + 1'b1) : v;
  endfunction

  // Pick the operand of the shared squarer
  always_comb begin
    mul_a = '0;
    case (state_r)
      S_SQX: mul_a = mag(x_r);
      S_SQZ: mul_a = mag(z_r);
      S_YSQ: begin
        case (sel_r)
          SEL_BOTTOM: mul_a = mag(min_y_r);
          SEL_TOP:    mul_a = mag(max_y_r);
          default:    mul_a = '0;
        endcase
      end
      default: mul_a = '0;
    endcase
  end

  assign mul_p      = mul_a * mul_a;
  assign rsq        = acc_r + p_r;
  assign radicand   = max_rsq_r + p_r;
  assign root_start = (state_r == S_GO);
  assign in_tready  = (state_r == S_IDLE);

  bcv_sqrt #(.ROOT_W(CW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (radicand),
    .root     (root),
    .stat     (root_stat)
  );

  // Size the result fields to 16 bits
  assign depth   = (top_r > bottom_r) ? top_r : bottom_r;
  assign min_ext = SEXT_W'(min_y_r);
  assign max_ext = SEXT_W'(max_y_r);
  assign rad_ext = UEXT_W'(radius_r);
  assign bot_ext = UEXT_W'(bottom_r);
  assign top_ext = UEXT_W'(top_r);
  assign dep_ext = UEXT_W'(depth);

  // Sequencer, running state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= SEL_RADIUS;
      out_valid_r <= 1'b0;
      min_y_r     <= COORD_MAX;
      max_y_r     <= COORD_MIN;
      max_rsq_r   <= '0;
    end else begin
      // Drop a result once the downstream side takes it, unless a new one loads now
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            x_r     <= in_tdata[CW-1:0];
            y_r     <= in_tdata[2*CW-1:CW];
            z_r     <= in_tdata[3*CW-1:2*CW];
            last_r  <= in_tlast;
            state_r <= S_SQX;
          end
        end
        S_SQX: begin
          p_r <= mul_p;
          if (y_r < min_y_r) min_y_r <= y_r;
          if (y_r > max_y_r) max_y_r <= y_r;
          state_r <= S_SQZ;
        end
        S_SQZ: begin
          acc_r   <= p_r;
          p_r     <= mul_p;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (rsq > max_rsq_r) max_rsq_r <= rsq;
          if (last_r) begin
            sel_r   <= SEL_RADIUS;
            state_r <= S_YSQ;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_YSQ: begin
          p_r     <= mul_p;
          state_r <= S_GO;
        end
        S_GO: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (root_stat.done) begin
            case (sel_r)
              SEL_RADIUS: begin
                radius_r <= root;
                sel_r    <= SEL_BOTTOM;
                state_r  <= S_YSQ;
              end
              SEL_BOTTOM: begin
                bottom_r <= EDGE_W'(root) + 1'b1;
                sel_r    <= SEL_TOP;
                state_r  <= S_YSQ;
              end
              default: begin
                top_r   <= EDGE_W'(root) + 1'b1;
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          // Hold until the output register is free, then restart the model
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {dep_ext[OUT_W-1:0], top_ext[OUT_W-1:0],
                            bot_ext[OUT_W-1:0], rad_ext[OUT_W-1:0],
                            max_ext[OUT_W-1:0], min_ext[OUT_W-1:0]};
            out_valid_r <= 1'b1;
            min_y_r     <= COORD_MAX;
            max_y_r     <= COORD_MIN;
            max_rsq_r   <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[tb/sv/bounding_cylinder_from_vertices_test.sv]
`timescale 1ns / 1ps
// Self-checking test of bounding_cylinder_from_vertices: streams vertex models and
// compares each cylinder result against a local running min/max/radius predictor.
// Depends on bcv_pkg and the bounding_cylinder_from_vertices RTL.
module bounding_cylinder_from_vertices_test import bcv_pkg::*; ();

  localparam int unsigned CW = 16;
  localparam int unsigned IN_W = ((3*CW+7)/8)*8;
  localparam int unsigned RES_W = OUT_FIELDS*OUT_W;
  localparam int unsigned RANDOM_VERTICES = 1700;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  // Idle time after the last expected result is taken, so that a stray result is still seen.
  localparam int unsigned DRAIN_CYCLES = 150;

  typedef logic signed [CW-1:0] coord_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tready = 1'b0;
  wire in_tready;
  wire out_tvalid;
  wire [RES_W-1:0] out_tdata;

  bounding_cylinder_from_vertices #(.COORD_WIDTH(CW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Running state of the model being streamed
  coord_t lowest_so_far;
  coord_t highest_so_far;
  logic [63:0] widest_rsq;

  logic [RES_W-1:0] pending_cylinders[$];
  logic [RES_W-1:0] expected_word;
  string field_names[OUT_FIELDS] = '{"lowest_y", "highest_y", "radius_out",
                                     "bottom_edge_dist", "top_edge_dist",
                                     "depth_any_rotation"};

  int unsigned cycle_count = 0;
  int unsigned vertices_sent = 0;
  int unsigned models_sent = 0;
  int unsigned cylinders_checked = 0;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  bit sender_bursty = 1'b0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_cylinders.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stall the result side on a pattern of its own: open, coin flip, one in four, shut
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) != 0);
      2: out_tready <= (cycle_count % 4 == 0);
      default: out_tready <= 1'b0;
    endcase
  end

  // Compare each accepted result with the oldest prediction, field by field
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cylinders.size() == 0) begin
        $display("%0t: unexpected result, expected none, got 0x%h", $time, out_tdata);
        mismatches++;
      end else begin
        expected_word = pending_cylinders.pop_front();
        for (int k = 0; k < OUT_FIELDS; k++) begin
          if (out_tdata[k*OUT_W +: OUT_W] !== expected_word[k*OUT_W +: OUT_W]) begin
            $display("%0t: %s expected 0x%h got 0x%h", $time, field_names[k],
                     expected_word[k*OUT_W +: OUT_W], out_tdata[k*OUT_W +: OUT_W]);
            mismatches++;
          end
        end
        cylinders_checked++;
      end
    end
  end

  function automatic logic [63:0] mag_squared(input coord_t v);
    longint m;
    m = v;
    if (m < 0) m = -m;
    return m * m;
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  task automatic clear_cylinder();
    lowest_so_far = {1'b0, {(CW-1){1'b1}}};
    highest_so_far = {1'b1, {(CW-1){1'b0}}};
    widest_rsq = '0;
  endtask

  // Fold one accepted vertex in; on the last one, queue the predicted cylinder
  task automatic fold_vertex(input coord_t x, input coord_t y, input coord_t z,
                             input logic last);
    logic [63:0] rsq;
    logic [63:0] radius;
    logic [63:0] bottom;
    logic [63:0] top;
    logic [63:0] depth;
    logic [RES_W-1:0] cyl;
    if (y < lowest_so_far) lowest_so_far = y;
    if (y > highest_so_far) highest_so_far = y;
    rsq = mag_squared(x) + mag_squared(z);
    if (rsq > widest_rsq) widest_rsq = rsq;
    if (last) begin
      radius = floor_root(widest_rsq);
      bottom = floor_root(widest_rsq + mag_squared(lowest_so_far)) + 1;
      top = floor_root(widest_rsq + mag_squared(highest_so_far)) + 1;
      depth = (top > bottom) ? top : bottom;
      cyl = '0;
      cyl[0*OUT_W +: OUT_W] = lowest_so_far;
      cyl[1*OUT_W +: OUT_W] = highest_so_far;
      cyl[2*OUT_W +: OUT_W] = radius[OUT_W-1:0];
      cyl[3*OUT_W +: OUT_W] = bottom[OUT_W-1:0];
      cyl[4*OUT_W +: OUT_W] = top[OUT_W-1:0];
      cyl[5*OUT_W +: OUT_W] = depth[OUT_W-1:0];
      pending_cylinders.push_back(cyl);
      models_sent++;
      clear_cylinder();
    end
  endtask

  // Send one vertex request; call at a rising edge, returns at the accepting edge
  task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z,
                             input logic last);
    logic [IN_W-1:0] word;
    if (sender_bursty) begin
      if (burst_left == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    word = '0;
    word[3*CW-1:0] = {z, y, x};
    in_tvalid <= 1'b1;
    in_tdata <= word;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fold_vertex(x, y, z, last);
    vertices_sent++;
  endtask

  function automatic coord_t pick_coord(input int unsigned style);
    case ($urandom_range(0, 9))
      0: return {1'b1, {(CW-1){1'b0}}};
      1: return {1'b0, {(CW-1){1'b1}}};
      2: return coord_t'($signed($urandom_range(0, 2)) - 1);
      default: begin
        if (style == 1) return coord_t'($signed($urandom_range(0, 512)) - 256);
        return coord_t'($urandom());
      end
    endcase
  endfunction

  // One-vertex models at the corners and near the centre of the coordinate range
  task automatic test_single_vertex_models();
    sender_bursty = 1'b0;
    send_vertex(0, 0, 0, 1'b1);
    send_vertex(-32768, -32768, -32768, 1'b1);
    send_vertex(32767, 32767, 32767, 1'b1);
    send_vertex(-32768, 0, 32767, 1'b1);
    send_vertex(1, -1, -1, 1'b1);
    send_vertex(32767, -32768, -32768, 1'b1);
    send_vertex(-1, 32767, 0, 1'b1);
  endtask

  // Short models where earlier vertices carry some of the extremes
  task automatic test_short_models();
    sender_bursty = 1'b0;
    send_vertex(100, -5, 0, 1'b0);
    send_vertex(0, 20, -300, 1'b0);
    send_vertex(3, 4, 5, 1'b1);
    // flat model: y never changes
    send_vertex(-32768, 7, -32768, 1'b0);
    send_vertex(0, 7, 0, 1'b1);
    // widest radius first, tallest span later
    send_vertex(32767, -32768, 32767, 1'b0);
    send_vertex(1, 1, 1, 1'b0);
    send_vertex(0, 32767, 0, 1'b1);
    send_vertex(-2, 300, 9, 1'b0);
    send_vertex(5, 200, -7, 1'b0);
    send_vertex(-40, 100, 40, 1'b0);
    send_vertex(0, -100, 0, 1'b1);
  endtask

  // Random models, mostly short, some long, with bursty and steady stretches
  task automatic test_random_models();
    int unsigned len;
    int unsigned style;
    while (vertices_sent < RANDOM_VERTICES) begin
      case ($urandom_range(0, 19))
        0: len = $urandom_range(60, 150);
        1, 2, 3, 4, 5: len = $urandom_range(9, 40);
        default: len = $urandom_range(1, 8);
      endcase
      style = $urandom_range(0, 1);
      sender_bursty = ($urandom_range(0, 4) != 0);
      for (int unsigned i = 0; i < len; i++) begin
        send_vertex(pick_coord(style), pick_coord(style), pick_coord(style), i == len - 1);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    clear_cylinder();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_single_vertex_models();
    test_short_models();
    test_random_models();
    while (pending_cylinders.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Streamed %0d vertices in %0d models; compared %0d cylinder results",
             vertices_sent, models_sent, cylinders_checked);
    $display("Field mismatches or stray results: %0d", mismatches);
    if (mismatches == 0 && pending_cylinders.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
